// ===== sv/fasta_fastq_kmer_encoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// fasta_fastq_kmer_encoder_core_defines
// Assertion macros shared by the k-mer encoder RTL.
// ----------------------------------------------------------------------------
`ifndef FASTA_FASTQ_KMER_ENCODER_CORE_DEFINES_SVH
`define FASTA_FASTQ_KMER_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFKE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFKE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ffke_pkg.sv =====
// ----------------------------------------------------------------------------
// ffke_pkg
// Shared types, codes and the base lookup table of the k-mer encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffke_pkg;

    localparam int MAX_KMER_DEF = 32;
    localparam int OUT_W        = 64;
    localparam int CFG_DATA_W   = 6;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT = 1'b1;

    localparam logic [5:0] KMER_LENGTH_RST = 6'd31;

    localparam logic [1:0] FMT_FASTA = 2'd0;
    localparam logic [1:0] FMT_FASTQ = 2'd1;
    localparam logic [1:0] FMT_RAW   = 2'd2;

    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_AT = 8'h40;

    typedef enum logic [4:0] {
        LS_SEQ  = 5'b00001,
        LS_HEAD = 5'b00010,
        LS_SEP  = 5'b00100,
        LS_PLUS = 5'b01000,
        LS_QUAL = 5'b10000
    } line_state_t;

    typedef struct packed {
        line_state_t line_next;
        logic        brk;
        logic        shift;
        logic [1:0]  code;
    } line_ctl_t;

    // Low five bits of a letter to its 2-bit code; bit 2 set means no base.
    function automatic logic [2:0] base_code(input logic [4:0] idx);
        logic [2:0] r;
        unique case (idx)
            5'd1:    r = 3'd0;  // A
            5'd3:    r = 3'd1;  // C
            5'd7:    r = 3'd3;  // G
            5'd20:   r = 3'd2;  // T
            default: r = 3'd4;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ffke_line_ctl.sv =====
// ----------------------------------------------------------------------------
// ffke_line_ctl
// Line-state decode: classifies one byte against the record structure of
// the selected format and decides shift, break and next line state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffke_line_ctl (
    input  logic [7:0]             in_byte,
    input  logic                   fresh_chunk,
    input  logic [1:0]             input_format,
    input  ffke_pkg::line_state_t  line_state,
    output ffke_pkg::line_ctl_t    ctl
);

    logic                  is_fasta;
    logic                  is_fastq;
    logic                  is_nl;
    logic [2:0]            code_full;
    ffke_pkg::line_state_t st;

    assign is_fasta  = (input_format == ffke_pkg::FMT_FASTA);
    assign is_fastq  = (input_format == ffke_pkg::FMT_FASTQ);
    assign is_nl     = (in_byte == ffke_pkg::CH_NL);
    assign code_full = (in_byte[7:6] == 2'b01) ? ffke_pkg::base_code(in_byte[4:0]) : 3'd4;

    // Fold line states the current format does not have back to sequence.
    always_comb begin
        st = fresh_chunk ? ffke_pkg::LS_SEQ : line_state;
        if (!is_fastq && (st == ffke_pkg::LS_SEP || st == ffke_pkg::LS_PLUS ||
                          st == ffke_pkg::LS_QUAL)) begin
            st = ffke_pkg::LS_SEQ;
        end
        if (!is_fasta && !is_fastq && st == ffke_pkg::LS_HEAD) begin
            st = ffke_pkg::LS_SEQ;
        end
    end

    always_comb begin
        ctl.line_next = st;
        ctl.brk       = 1'b0;
        ctl.shift     = 1'b0;
        ctl.code      = code_full[1:0];
        unique case (st)
            ffke_pkg::LS_HEAD: begin
                if (is_nl) ctl.line_next = ffke_pkg::LS_SEQ;
            end
            ffke_pkg::LS_SEP: begin
                ctl.line_next = is_nl ? ffke_pkg::LS_QUAL : ffke_pkg::LS_PLUS;
            end
            ffke_pkg::LS_PLUS: begin
                if (is_nl) ctl.line_next = ffke_pkg::LS_QUAL;
            end
            ffke_pkg::LS_QUAL: begin
                if (is_nl) ctl.line_next = ffke_pkg::LS_SEQ;
            end
            default: begin
                // Sequence line.
                if (is_fasta && is_nl) begin
                    // newline inside a FASTA sequence: transparent
                end else if (is_fasta && in_byte == ffke_pkg::CH_GT) begin
                    ctl.line_next = ffke_pkg::LS_HEAD;
                    ctl.brk       = 1'b1;
                end else if (is_fastq && in_byte == ffke_pkg::CH_AT) begin
                    ctl.line_next = ffke_pkg::LS_HEAD;
                    ctl.brk       = 1'b1;
                end else if (is_fastq && is_nl) begin
                    ctl.line_next = ffke_pkg::LS_SEP;
                    ctl.brk       = 1'b1;
                end else if (code_full[2]) begin
                    ctl.brk = 1'b1;
                end else begin
                    ctl.shift = 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== sv/fasta_fastq_kmer_encoder_core.sv =====
// ----------------------------------------------------------------------------
// fasta_fastq_kmer_encoder_core
// Output: the result is registered and appears in the cycle after the base byte transfers.
// Throughput: one byte per cycle while the output register is empty or draining;
// the line-state, fill count and k-mer shift registers take their next values combinationally.
// Reset: aresetn low (sync) empties the output register, clears fill and k-mers,
// returns to start of record, kmer_length 31, input_format FASTA.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fasta_fastq_kmer_encoder_core_defines.svh"

module fasta_fastq_kmer_encoder_core #(
    parameter int MAX_KMER = ffke_pkg::MAX_KMER_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_we,
    input  logic [ffke_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffke_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // byte stream in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_in_byte,
    input  logic                            s_fresh_chunk,

    // k-mer results out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ffke_pkg::OUT_W-1:0]      m_forward_kmer,
    output logic [ffke_pkg::OUT_W-1:0]      m_reverse_kmer
);

    // Width of one k-mer register, width of a base count, width of a shift.
    localparam int KW  = 2 * MAX_KMER;
    localparam int KCW = $clog2(MAX_KMER + 1);
    localparam int SW  = KCW + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0] kmer_length_reg;
    logic [1:0] input_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kmer_length_reg  <= ffke_pkg::KMER_LENGTH_RST;
            input_format_reg <= ffke_pkg::FMT_FASTA;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ffke_pkg::REG_KMER_LENGTH:  kmer_length_reg  <= cfg_wdata[5:0];
                ffke_pkg::REG_INPUT_FORMAT: input_format_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Clamp the programmed length: zero acts as one, oversize as MAX_KMER.
    logic [KCW-1:0] k_eff;

    always_comb begin
        if (kmer_length_reg == 6'd0) begin
            k_eff = KCW'(1);
        end else if (kmer_length_reg > 6'(MAX_KMER)) begin
            k_eff = KCW'(MAX_KMER);
        end else begin
            k_eff = KCW'(kmer_length_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the output register parts the two sides, so accept a new
    // byte whenever that register is empty or being drained this cycle.
    // ------------------------------------------------------------------
    logic s_xfer;
    logic m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Record structure decode
    // ------------------------------------------------------------------
    ffke_pkg::line_state_t line_state_reg;
    ffke_pkg::line_ctl_t   ctl;

    ffke_line_ctl u_line_ctl (
        .in_byte      (s_in_byte),
        .fresh_chunk  (s_fresh_chunk),
        .input_format (input_format_reg),
        .line_state   (line_state_reg),
        .ctl          (ctl)
    );

    // ------------------------------------------------------------------
    // Fill count and k-mer shift registers
    // ------------------------------------------------------------------
    logic [KCW-1:0] fill_reg;
    logic [KCW-1:0] fill_base;
    logic [KCW-1:0] fill_inc;
    logic [KCW-1:0] fill_next;
    logic [KW-1:0]  fwd_reg;
    logic [KW-1:0]  rev_reg;
    logic [KW+1:0]  fwd_cat;
    logic [KW+1:0]  rev_cat;
    logic [KW-1:0]  fwd_next;
    logic [KW-1:0]  rev_next;
    logic           emit;

    // A fresh chunk restarts the fill before the byte is handled.
    assign fill_base = s_fresh_chunk ? '0 : fill_reg;
    // Saturate at MAX_KMER so the count never wraps.
    assign fill_inc  = (fill_base < KCW'(MAX_KMER)) ? fill_base + KCW'(1) : fill_base;

    always_comb begin
        if (ctl.brk) begin
            fill_next = '0;
        end else if (ctl.shift) begin
            fill_next = fill_inc;
        end else begin
            fill_next = fill_base;
        end
    end

    // Newest base enters the forward k-mer at the low end and, complemented,
    // the reverse k-mer at the high end.
    assign fwd_cat  = {fwd_reg, ctl.code};
    assign rev_cat  = {ctl.code ^ 2'b10, rev_reg};
    assign fwd_next = fwd_cat[KW-1:0];
    assign rev_next = rev_cat[KW+1:2];

    assign emit = ctl.shift && (fill_inc >= k_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_state_reg <= ffke_pkg::LS_SEQ;
            fill_reg       <= '0;
            fwd_reg        <= '0;
            rev_reg        <= '0;
        end else if (s_xfer) begin
            line_state_reg <= ctl.line_next;
            fill_reg       <= fill_next;
            if (ctl.shift) begin
                fwd_reg <= fwd_next;
                rev_reg <= rev_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result formatting: mask the forward k-mer to 2k bits and right-align
    // the reverse k-mer by dropping the stale low bases.
    // ------------------------------------------------------------------
    logic [KW-1:0] fwd_mask;
    logic [SW-1:0] rev_shamt;
    logic [KW-1:0] fwd_out;
    logic [KW-1:0] rev_out;

    always_comb begin
        for (int j = 0; j < KW; j++) begin
            fwd_mask[j] = ((j >> 1) < int'(k_eff));
        end
    end

    assign rev_shamt = SW'(KW) - {k_eff, 1'b0};
    assign fwd_out   = fwd_next & fwd_mask;
    assign rev_out   = rev_next >> rev_shamt;

    // ------------------------------------------------------------------
    // Output register: load on a base that completes a k-mer, drop valid
    // once the result transfers.
    // ------------------------------------------------------------------
    logic [KW-1:0] m_fwd_reg;
    logic [KW-1:0] m_rev_reg;
    logic          m_valid_next;

    always_comb begin
        if (s_xfer) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            m_fwd_reg <= fwd_out;
            m_rev_reg <= rev_out;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_forward_kmer = ffke_pkg::OUT_W'(m_fwd_reg);
    assign m_reverse_kmer = ffke_pkg::OUT_W'(m_rev_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A byte that completes no k-mer leaves nothing in the output register.
    `FFKE_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn, s_xfer && !emit, !m_valid_reg, "result without a completed k-mer")
    // A break always restarts the fill.
    `FFKE_ASSERT_NEXT(a_break_clears_fill, aclk, aresetn, s_xfer && ctl.brk, fill_reg == '0, "fill not cleared on break")
    // Shift and break never both fire for one byte.
    `FFKE_ASSERT_NOW(a_shift_xor_break, aclk, aresetn, s_xfer, !(ctl.shift && ctl.brk), "byte both shifted and broke the k-mer")
    // The fill count saturates at the maximum k-mer length.
    `FFKE_ASSERT_NOW(a_fill_bounded, aclk, aresetn, 1'b1, fill_reg <= KCW'(MAX_KMER), "fill count above maximum")

endmodule

// ===== tb/sv/fasta_fastq_kmer_encoder_core_test.sv =====
// ----------------------------------------------------------------------------
// fasta_fastq_kmer_encoder_core_test
// Drives FASTA, FASTQ and raw byte streams into the k-mer encoder under random
// idling on both handshakes and checks every forward and reverse-complement
// k-mer against a cycle-free prediction of the line parser and shift registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fasta_fastq_kmer_encoder_core_test;

    import ffke_pkg::*;

    // Nucleotide codes as they land in the k-mer registers; NT_NONE breaks.
    localparam logic [2:0] NT_A    = 3'd0;
    localparam logic [2:0] NT_C    = 3'd1;
    localparam logic [2:0] NT_T    = 3'd2;
    localparam logic [2:0] NT_G    = 3'd3;
    localparam logic [2:0] NT_NONE = 3'd4;

    // Format code 3 is not listed but decodes like raw lines.
    localparam logic [1:0] FMT_RAW_ALIAS = 2'd3;

    localparam logic [7:0] CH_PLUS = "+";

    localparam int PHASES        = 13;
    localparam int PHASE_BYTES   = 125;
    localparam int MAX_GAP       = 19;
    localparam int STALL_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_CAP    = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [63:0] fwd;
        logic [63:0] rev;
    } kmer_pair_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_in_byte     = 8'h00;
    logic                  s_fresh_chunk = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [OUT_W-1:0]      m_forward_kmer;
    logic [OUT_W-1:0]      m_reverse_kmer;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    fasta_fastq_kmer_encoder_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_fresh_chunk  (s_fresh_chunk),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_forward_kmer (m_forward_kmer),
        .m_reverse_kmer (m_reverse_kmer)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the encoder: configuration, line state, fill and k-mers.
    // ------------------------------------------------------------------------
    logic [5:0]  cfg_k       = KMER_LENGTH_RST;
    logic [1:0]  cfg_fmt     = FMT_FASTA;
    line_state_t parse_state = LS_SEQ;
    logic [5:0]  seq_fill    = '0;
    logic [63:0] fwd_shift   = '0;
    logic [63:0] rc_shift    = '0;

    kmer_pair_t expected_kmers[$];

    int  errors      = 0;
    int  bytes_sent  = 0;
    int  kmers_seen  = 0;
    int  reg_writes  = 0;
    int  cycle_count = 0;
    bit  tx_idle     = 1'b1;
    bit  rx_idle     = 1'b1;
    int  rx_hold     = 0;

    function automatic logic [2:0] nt_code(input logic [7:0] ch);
        case (ch)
            "A", "a": return NT_A;
            "C", "c": return NT_C;
            "G", "g": return NT_G;
            "T", "t": return NT_T;
            default:  return NT_NONE;
        endcase
    endfunction

    // Advance the shadow state by one accepted byte; queue a k-mer pair when
    // the fill reaches the effective length.
    task automatic encode_byte(input logic [7:0] ch, input logic fresh);
        logic [1:0] fmt;
        logic [2:0] nt;
        int         k;
        fmt = (cfg_fmt == FMT_RAW_ALIAS) ? FMT_RAW : cfg_fmt;
        if (fresh) begin
            seq_fill    = '0;
            parse_state = LS_SEQ;
        end
        // States the current format has no use for fall back to sequence.
        if (fmt != FMT_FASTQ &&
            (parse_state == LS_SEP || parse_state == LS_PLUS || parse_state == LS_QUAL))
            parse_state = LS_SEQ;
        if (fmt == FMT_RAW && parse_state == LS_HEAD)
            parse_state = LS_SEQ;

        case (parse_state)
            LS_HEAD: begin
                if (ch == CH_NL) parse_state = LS_SEQ;
                return;
            end
            LS_SEP: begin
                // A bare newline here is an empty plus line.
                parse_state = (ch == CH_NL) ? LS_QUAL : LS_PLUS;
                return;
            end
            LS_PLUS: begin
                if (ch == CH_NL) parse_state = LS_QUAL;
                return;
            end
            LS_QUAL: begin
                if (ch == CH_NL) parse_state = LS_SEQ;
                return;
            end
            default: ;
        endcase

        if (fmt == FMT_FASTA) begin
            if (ch == CH_NL) return;
            if (ch == CH_GT) begin
                parse_state = LS_HEAD;
                seq_fill    = '0;
                return;
            end
        end else if (fmt == FMT_FASTQ) begin
            if (ch == CH_AT) begin
                parse_state = LS_HEAD;
                seq_fill    = '0;
                return;
            end
            if (ch == CH_NL) begin
                parse_state = LS_SEP;
                seq_fill    = '0;
                return;
            end
        end

        nt = nt_code(ch);
        if (nt == NT_NONE) begin
            seq_fill = '0;
            return;
        end

        fwd_shift = {fwd_shift[61:0], nt[1:0]};
        rc_shift  = {nt[1:0] ^ 2'b10, rc_shift[63:2]};
        if (seq_fill < MAX_KMER_DEF) seq_fill = seq_fill + 1'b1;

        k = (cfg_k == 0) ? 1 : ((cfg_k > MAX_KMER_DEF) ? MAX_KMER_DEF : int'(cfg_k));
        if (seq_fill >= k) begin
            if (k == MAX_KMER_DEF)
                expected_kmers.push_back({fwd_shift, rc_shift});
            else
                expected_kmers.push_back({fwd_shift & ((64'd1 << (2 * k)) - 64'd1),
                                          rc_shift >> (64 - 2 * k)});
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side: one transfer per call, with a random idle gap first.
    // Returns at the edge where the byte was taken, valid still high.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] ch, input logic fresh);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= ch;
        s_fresh_chunk <= fresh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        encode_byte(ch, fresh);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt, input logic fresh_first);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], fresh_first && i == 0);
    endtask

    // Drop valid, wait out every queued k-mer plus the pipeline latency.
    task automatic drain();
        s_valid <= 1'b0;
        while (expected_kmers.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_KMER_LENGTH) cfg_k = data;
        else cfg_fmt = data[1:0];
        reg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_base();
        string letters;
        letters = "ACGTacgt";
        // An occasional N breaks the k-mer inside an otherwise clean line.
        if ($urandom_range(0, 39) == 0) return "N";
        return letters[$urandom_range(0, 7)];
    endfunction

    task automatic send_bases(input int n, input logic fresh);
        for (int i = 0; i < n; i++)
            send_byte(rand_base(), fresh && i == 0);
    endtask

    // Printable text up to a newline: header, plus or quality line.
    task automatic send_filler(input int n, input logic [7:0] lo);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(lo, 8'h7E)), 1'b0);
        send_byte(CH_NL, 1'b0);
    endtask

    task automatic send_record();
        logic [1:0] fmt;
        logic       fresh;
        int         len;
        fmt   = (cfg_fmt == FMT_RAW_ALIAS) ? FMT_RAW : cfg_fmt;
        fresh = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
            // Noise: arbitrary bytes, may leave the parser mid-line.
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else begin
            case (fmt)
                FMT_FASTA: begin
                    send_byte(CH_GT, fresh);
                    send_filler($urandom_range(0, 12), 8'h20);
                    repeat ($urandom_range(1, 3)) begin
                        send_bases($urandom_range(0, 40), 1'b0);
                        send_byte(CH_NL, 1'b0);
                    end
                end
                FMT_FASTQ: begin
                    send_byte(CH_AT, fresh);
                    send_filler($urandom_range(0, 12), 8'h20);
                    len = $urandom_range(0, 60);
                    send_bases(len, 1'b0);
                    send_byte(CH_NL, 1'b0);
                    if ($urandom_range(0, 1) == 0) begin
                        send_byte(CH_NL, 1'b0);
                    end else begin
                        send_byte(CH_PLUS, 1'b0);
                        send_filler($urandom_range(0, 8), 8'h20);
                    end
                    send_filler(len, 8'h21);
                end
                default: begin
                    send_bases($urandom_range(0, 50), fresh);
                    send_byte(CH_NL, 1'b0);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall per transfer, plus an optional long hold-off
    // that a test arms through rx_hold and this process counts down.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int rx_gap;
        rx_gap = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t ns: %s mismatch, expected %h actual %h",
                         $time, name, want, got);
        end
    endtask

    // Compare every result transfer with the oldest queued k-mer pair.
    always @(posedge aclk) begin : result_check
        kmer_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            kmers_seen++;
            if (expected_kmers.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t ns: unexpected k-mer, expected none actual %h / %h",
                             $time, m_forward_kmer, m_reverse_kmer);
            end else begin
                want = expected_kmers.pop_front();
                check_field("forward_kmer", want.fwd, m_forward_kmer);
                check_field("reverse_kmer", want.rev, m_reverse_kmer);
            end
        end
    end

    // Hard stop in case the handshake locks up.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t ns: timeout after %0d cycles, %0d k-mers still queued",
                 $time, cycle_count, expected_kmers.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // k = 1: every base of either case yields one k-mer; a byte with the high
    // bit set and a NUL break; length 0 behaves as 1.
    task automatic test_base_extremes();
        write_reg(REG_KMER_LENGTH, 6'd1);
        send_text("AcGt", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        write_reg(REG_KMER_LENGTH, 6'd0);
        send_text("T", 1'b0);
    endtask

    // FASTA: '>' breaks and the header is skipped; a newline inside the
    // sequence does not break the k-mer.
    task automatic test_fasta_header();
        write_reg(REG_KMER_LENGTH, 6'd2);
        send_text("AC>xA\nG\nT", 1'b0);
    endtask

    // FASTQ: header, sequence, empty plus line, empty quality line, then a
    // new record picks up in sequence state.
    task automatic test_fastq_record();
        write_reg(REG_INPUT_FORMAT, CFG_DATA_W'(FMT_FASTQ));
        write_reg(REG_KMER_LENGTH, 6'd1);
        send_text("@\nA\n\n\nC", 1'b0);
    endtask

    // Switch from FASTQ header state to format code 3: the header is dropped
    // and raw newline breaks.
    task automatic test_format_switch();
        send_byte(CH_AT, 1'b0);
        write_reg(REG_INPUT_FORMAT, CFG_DATA_W'(FMT_RAW_ALIAS));
        write_reg(REG_KMER_LENGTH, 6'd2);
        send_text("GA\nC", 1'b0);
    endtask

    // Hold the result side for a long stretch while bases keep coming, so
    // the output fills and input ready drops.
    task automatic test_backpressure();
        write_reg(REG_INPUT_FORMAT, CFG_DATA_W'(FMT_RAW));
        write_reg(REG_KMER_LENGTH, 6'd1);
        tx_idle = 1'b0;
        rx_hold = STALL_CYCLES;
        send_bases(40, 1'b0);
        tx_idle = 1'b1;
    endtask

    // Mostly well-formed records of the active format, some noise, across
    // settings that include both length extremes and every format code.
    task automatic test_random_phases();
        logic [5:0] k;
        logic [1:0] fmt;
        logic [3:0] pad;
        int         start;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       k = 6'd32;
                1:       k = 6'd63;
                2:       k = 6'd1;
                3:       k = 6'd0;
                4:       k = 6'd2;
                default: k = 6'($urandom_range(0, 63));
            endcase
            case (p % 4)
                0:       fmt = FMT_FASTA;
                1:       fmt = FMT_FASTQ;
                2:       fmt = FMT_RAW;
                default: fmt = FMT_RAW_ALIAS;
            endcase
            pad     = 4'($urandom_range(0, 15));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            write_reg(REG_KMER_LENGTH, k);
            // Upper data bits are don't-care for the format register.
            write_reg(REG_INPUT_FORMAT, {pad, fmt});
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) send_record();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : main
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_base_extremes();
        test_fasta_header();
        test_fastq_record();
        test_format_switch();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Summary: %0d bytes in %0d cycles, %0d register writes, %0d k-mer pairs",
                 bytes_sent, cycle_count, reg_writes, kmers_seen);
        $display("Summary: FASTA, FASTQ, raw and alias formats, k from 0 to 63, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
